### rtl/bl3_pkg.sv
`default_nettype none

package bl3_pkg;

  // coordinate width, which sets the field widths of the payload
  localparam int unsigned CoordBits = 12;
  // twice an absolute span
  localparam int unsigned SpanBits  = CoordBits + 1;
  // signed error term of a minor axis
  localparam int unsigned ErrBits   = CoordBits + 3;

  typedef enum logic {
    OpStart   = 1'b0,
    OpAdvance = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    AxisX = 2'd0,
    AxisY = 2'd1,
    AxisZ = 2'd2
  } axis_e;

  typedef logic signed [CoordBits-1:0] coord_t;
  typedef logic        [CoordBits-1:0] mag_t;
  typedef logic        [SpanBits-1:0]  span_t;
  typedef logic signed [ErrBits-1:0]   err_t;
  typedef logic signed [1:0]           step_t;

  typedef struct packed {
    op_e    op;
    coord_t start_x;
    coord_t start_y;
    coord_t start_z;
    coord_t end_x;
    coord_t end_y;
    coord_t end_z;
  } in_t;

  typedef struct packed {
    coord_t point_x;
    coord_t point_y;
    coord_t point_z;
    logic   point_valid;
    logic   point_last;
  } out_t;

  // one classified item on its way from the front to the walker
  typedef struct packed {
    op_e    op;
    coord_t start_x;
    coord_t start_y;
    coord_t start_z;
    coord_t major_end;
    axis_e  major_axis;
    logic   first_last;
    err_t   err_a;
    err_t   err_b;
    span_t  tspan_x;
    span_t  tspan_y;
    span_t  tspan_z;
    step_t  step_x;
    step_t  step_y;
    step_t  step_z;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmd_req_t;

  // first minor axis in axis order
  function automatic axis_e minor_a(axis_e major);
    minor_a = (major == AxisX) ? AxisY : AxisX;
  endfunction

  // second minor axis in axis order
  function automatic axis_e minor_b(axis_e major);
    minor_b = (major == AxisZ) ? AxisY : AxisZ;
  endfunction

endpackage

`default_nettype wire

### rtl/bresenham_line_3d_core.sv
// 3d line walker: emits one line point for every input transfer
// input channel: in_valid_i / in_stall_o carry in_data_i; op start loads
//   both endpoints and returns the first point, op advance returns the next
//   point, or a point with point_valid clear once the line has ended
// output channel: out_valid_o / out_stall_i carry out_data_o, exactly one
//   result per input transfer, in order; point_last marks the final endpoint
// each result passes from its input transfer through the setup register,
//   the command queue and the output register
// throughput: one item per cycle while the output is not stalled; the walker
//   does one error update per cycle on registered error terms, the setup
//   stage computes spans, major axis and initial errors ahead of it
// a stalled output holds its result; the command queue keeps taking items
//   until it fills, and once the setup register also holds a command
//   in_stall_o rises
// reset clears the valid flags, the queue and the line-active flag; no line
//   is active afterwards
`default_nettype none

module bresenham_line_3d_core #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  input  wire bl3_pkg::in_t  in_data_i,
  output logic               in_stall_o,
  output logic               out_valid_o,
  output bl3_pkg::out_t      out_data_o,
  input  wire logic          out_stall_i
);

  // classified command leaving the setup stage
  bl3_pkg::cmd_req_t push;
  // oldest queued command seen by the walker
  bl3_pkg::cmd_req_t head;
  logic              full;
  logic              pop;

  // setup: endpoint spans, step signs, dominant axis, initial error terms
  bl3_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_data_i  (in_data_i),
    .in_stall_o (in_stall_o),
    .push_o     (push),
    .full_i     (full)
  );

  // decouples setup from the walker so each side stalls on its own
  bl3_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .full_o (full),
    .head_o (head),
    .pop_i  (pop)
  );

  // walker: holds the line state and drives the output register
  bl3_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .out_stall_i (out_stall_i)
  );

endmodule

`default_nettype wire

### rtl/bl3_front.sv
`default_nettype none

module bl3_front (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  input  wire bl3_pkg::in_t      in_data_i,
  output logic                   in_stall_o,
  output bl3_pkg::cmd_req_t      push_o,
  input  wire logic              full_i
);

  bl3_pkg::coord_t              s      [3];
  bl3_pkg::coord_t              e      [3];
  logic signed [bl3_pkg::CoordBits:0] d [3];
  bl3_pkg::mag_t                mag    [3];
  bl3_pkg::span_t               tspan  [3];
  bl3_pkg::step_t               step   [3];
  bl3_pkg::axis_e               major;
  bl3_pkg::axis_e               ma;
  bl3_pkg::axis_e               mb;
  bl3_pkg::cmd_t                cmd;
  logic                         valid_q;
  bl3_pkg::cmd_t                cmd_q;
  logic                         accept;

  always_comb begin
    s[0] = in_data_i.start_x;
    s[1] = in_data_i.start_y;
    s[2] = in_data_i.start_z;
    e[0] = in_data_i.end_x;
    e[1] = in_data_i.end_y;
    e[2] = in_data_i.end_z;
    for (int i = 0; i < 3; i++) begin
      d[i]     = {e[i][bl3_pkg::CoordBits-1], e[i]} - {s[i][bl3_pkg::CoordBits-1], s[i]};
      mag[i]   = d[i][bl3_pkg::CoordBits] ? bl3_pkg::mag_t'(-d[i])
                                          : bl3_pkg::mag_t'(d[i]);
      tspan[i] = {mag[i], 1'b0};
      step[i]  = d[i][bl3_pkg::CoordBits] ? 2'sb11 : ((d[i] != '0) ? 2'sb01 : 2'sb00);
    end
  end

  // dominant axis, ties go to x then y
  always_comb begin
    priority if (mag[0] >= mag[1] && mag[0] >= mag[2]) begin
      major = bl3_pkg::AxisX;
    end else if (mag[1] >= mag[2]) begin
      major = bl3_pkg::AxisY;
    end else begin
      major = bl3_pkg::AxisZ;
    end
    ma = bl3_pkg::minor_a(major);
    mb = bl3_pkg::minor_b(major);
  end

  always_comb begin
    cmd            = '0;
    cmd.op         = in_data_i.op;
    cmd.start_x    = s[0];
    cmd.start_y    = s[1];
    cmd.start_z    = s[2];
    cmd.major_end  = e[major];
    cmd.major_axis = major;
    cmd.first_last = (s[major] == e[major]);
    cmd.err_a      = bl3_pkg::err_t'({2'b00, tspan[ma]}) - bl3_pkg::err_t'({3'b000, mag[major]});
    cmd.err_b      = bl3_pkg::err_t'({2'b00, tspan[mb]}) - bl3_pkg::err_t'({3'b000, mag[major]});
    cmd.tspan_x    = tspan[0];
    cmd.tspan_y    = tspan[1];
    cmd.tspan_z    = tspan[2];
    cmd.step_x     = step[0];
    cmd.step_y     = step[1];
    cmd.step_z     = step[2];
  end

  assign in_stall_o = valid_q && full_i;
  assign accept     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (accept) begin
      valid_q <= 1'b1;
    end else if (!full_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= cmd;
    end
  end

  assign push_o.valid = valid_q;
  assign push_o.cmd   = cmd_q;

endmodule

`default_nettype wire

### rtl/bl3_queue.sv
`default_nettype none

module bl3_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire bl3_pkg::cmd_req_t push_i,
  output logic                   full_o,
  output bl3_pkg::cmd_req_t      head_o,
  input  wire logic              pop_i
);

  localparam int unsigned PtrBits = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntBits = $clog2(DEPTH + 1);

  bl3_pkg::cmd_t        mem_q [DEPTH];
  logic [PtrBits-1:0]   wr_ptr_q;
  logic [PtrBits-1:0]   rd_ptr_q;
  logic [CntBits-1:0]   count_q;
  logic                 do_push;
  logic                 do_pop;

  assign full_o       = (count_q == CntBits'(DEPTH));
  assign do_push      = push_i.valid && !full_o;
  assign do_pop       = pop_i && (count_q != '0);
  assign head_o.valid = (count_q != '0);
  assign head_o.cmd   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrBits'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrBits'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (!do_push && do_pop) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_i.cmd;
    end
  end

endmodule

`default_nettype wire

### rtl/bl3_back.sv
`default_nettype none

module bl3_back (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire bl3_pkg::cmd_req_t head_i,
  output logic                   pop_o,
  output logic                   out_valid_o,
  output bl3_pkg::out_t          out_data_o,
  input  wire logic              out_stall_i
);

  bl3_pkg::coord_t cur_q   [3];
  bl3_pkg::span_t  tspan_q [3];
  bl3_pkg::step_t  step_q  [3];
  bl3_pkg::coord_t major_end_q;
  bl3_pkg::axis_e  major_q;
  bl3_pkg::err_t   err_a_q;
  bl3_pkg::err_t   err_b_q;
  logic            active_q;
  logic            out_valid_q;
  bl3_pkg::out_t   out_q;

  bl3_pkg::coord_t cur_n   [3];
  bl3_pkg::err_t   err_a_n;
  bl3_pkg::err_t   err_b_n;
  bl3_pkg::axis_e  ma;
  bl3_pkg::axis_e  mb;
  bl3_pkg::span_t  tmaj;
  logic            step_a;
  logic            step_b;
  logic            adv_last;

  function automatic bl3_pkg::coord_t ext_step(bl3_pkg::step_t st);
    ext_step = {{(bl3_pkg::CoordBits-2){st[1]}}, st};
  endfunction

  assign pop_o = head_i.valid && (!out_valid_q || !out_stall_i);

  // one step of the walk from the held state
  always_comb begin
    ma     = bl3_pkg::minor_a(major_q);
    mb     = bl3_pkg::minor_b(major_q);
    tmaj   = tspan_q[major_q];
    step_a = !err_a_q[bl3_pkg::ErrBits-1];
    step_b = !err_b_q[bl3_pkg::ErrBits-1];
    for (int i = 0; i < 3; i++) begin
      cur_n[i] = cur_q[i];
    end
    if (step_a) begin
      cur_n[ma] = cur_q[ma] + ext_step(step_q[ma]);
    end
    if (step_b) begin
      cur_n[mb] = cur_q[mb] + ext_step(step_q[mb]);
    end
    cur_n[major_q] = cur_q[major_q] + ext_step(step_q[major_q]);
    err_a_n  = err_a_q + bl3_pkg::err_t'({2'b00, tspan_q[ma]})
             - (step_a ? bl3_pkg::err_t'({2'b00, tmaj}) : '0);
    err_b_n  = err_b_q + bl3_pkg::err_t'({2'b00, tspan_q[mb]})
             - (step_b ? bl3_pkg::err_t'({2'b00, tmaj}) : '0);
    adv_last = (cur_n[major_q] == major_end_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (pop_o) begin
      out_valid_q <= 1'b1;
      unique case (head_i.cmd.op)
        bl3_pkg::OpStart: begin
          active_q <= !head_i.cmd.first_last;
        end
        bl3_pkg::OpAdvance: begin
          if (active_q) begin
            active_q <= !adv_last;
          end
        end
        default: begin
          active_q <= active_q;
        end
      endcase
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      unique case (head_i.cmd.op)
        bl3_pkg::OpStart: begin
          cur_q[0]    <= head_i.cmd.start_x;
          cur_q[1]    <= head_i.cmd.start_y;
          cur_q[2]    <= head_i.cmd.start_z;
          tspan_q[0]  <= head_i.cmd.tspan_x;
          tspan_q[1]  <= head_i.cmd.tspan_y;
          tspan_q[2]  <= head_i.cmd.tspan_z;
          step_q[0]   <= head_i.cmd.step_x;
          step_q[1]   <= head_i.cmd.step_y;
          step_q[2]   <= head_i.cmd.step_z;
          major_end_q <= head_i.cmd.major_end;
          major_q     <= head_i.cmd.major_axis;
          err_a_q     <= head_i.cmd.err_a;
          err_b_q     <= head_i.cmd.err_b;
          out_q.point_x     <= head_i.cmd.start_x;
          out_q.point_y     <= head_i.cmd.start_y;
          out_q.point_z     <= head_i.cmd.start_z;
          out_q.point_valid <= 1'b1;
          out_q.point_last  <= head_i.cmd.first_last;
        end
        bl3_pkg::OpAdvance: begin
          if (active_q) begin
            for (int i = 0; i < 3; i++) begin
              cur_q[i] <= cur_n[i];
            end
            err_a_q           <= err_a_n;
            err_b_q           <= err_b_n;
            out_q.point_x     <= cur_n[0];
            out_q.point_y     <= cur_n[1];
            out_q.point_z     <= cur_n[2];
            out_q.point_valid <= 1'b1;
            out_q.point_last  <= adv_last;
          end else begin
            out_q <= '0;
          end
        end
        default: begin
          out_q <= '0;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire
